// File: sv/battery_soc_estimator_unit_defines.svh
// Assertion macros for the battery gauge
`ifndef BATTERY_SOC_ESTIMATOR_UNIT_DEFINES_SVH
`define BATTERY_SOC_ESTIMATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BSE_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSE_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSE_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BSE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: sv/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Types, constants and the OCV table of the battery gauge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bse_pkg;
  localparam int OCV_ENTRIES = 51;
  localparam int PCT_FULL = 25600;
  localparam int PCT_CAP = 25344;
  localparam int MV_Q8_MAX = 4194303;

  localparam logic [2:0] REG_DIV = 3'd0;
  localparam logic [2:0] REG_CAL = 3'd1;
  localparam logic [2:0] REG_CHG = 3'd2;
  localparam logic [2:0] REG_SHD = 3'd3;
  localparam logic [2:0] REG_DEB = 3'd4;
  localparam logic [2:0] REG_VA  = 3'd5;
  localparam logic [2:0] REG_SA  = 3'd6;
  localparam logic [2:0] REG_DA  = 3'd7;

  localparam logic [1:0] CHG_DISC = 2'd0;
  localparam logic [1:0] CHG_ON   = 2'd1;
  localparam logic [1:0] CHG_DONE = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [11:0] adc_mv;
    logic        detect_active;
    logic        done_active;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  display_percent;
    logic [14:0] soc_q8;
    logic [13:0] filtered_mv_out;
    logic [1:0]  charger_state;
    logic        shutdown_needed;
  } out_item_t;

  // gauge state word kept in the state memory
  typedef struct packed {
    logic [1:0]  chg;
    logic [1:0]  cand;
    logic [31:0] since;
    logic [21:0] filt;
    logic [15:0] soc;
    logic [15:0] disp;
    logic        shd;
    logic        seeded;
  } gauge_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_PRE, ST_FILT, ST_SEARCH, ST_DIV, ST_SOC, ST_DISP, ST_WB, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [21:0] v;
  } ocv_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] pct;
  } ocv_rsp_t;

  function automatic logic [31:0] ocv_entry(input int i);
    logic [31:0] t [0:OCV_ENTRIES-1];
    t = '{
      {16'd4200,16'd25600},{16'd4150,16'd25344},{16'd4130,16'd25088},
      {16'd4100,16'd24832},{16'd4060,16'd24576},{16'd4030,16'd24320},
      {16'd4010,16'd24064},{16'd3990,16'd23808},{16'd3970,16'd23552},
      {16'd3950,16'd23296},{16'd3930,16'd23040},{16'd3910,16'd22528},
      {16'd3900,16'd22016},{16'd3890,16'd21504},{16'd3880,16'd20992},
      {16'd3870,16'd20480},{16'd3860,16'd19968},{16'd3850,16'd19456},
      {16'd3840,16'd18688},{16'd3830,16'd17920},{16'd3820,16'd17152},
      {16'd3810,16'd16384},{16'd3800,16'd15616},{16'd3790,16'd14848},
      {16'd3780,16'd14080},{16'd3770,16'd13312},{16'd3760,16'd12544},
      {16'd3750,16'd11776},{16'd3740,16'd11008},{16'd3730,16'd10240},
      {16'd3720,16'd9472},{16'd3710,16'd8704},{16'd3700,16'd7936},
      {16'd3690,16'd7168},{16'd3680,16'd6400},{16'd3670,16'd5888},
      {16'd3660,16'd5376},{16'd3650,16'd4864},{16'd3640,16'd4352},
      {16'd3620,16'd3840},{16'd3600,16'd3328},{16'd3580,16'd2816},
      {16'd3560,16'd2304},{16'd3540,16'd2048},{16'd3520,16'd1792},
      {16'd3490,16'd1536},{16'd3450,16'd1152},{16'd3420,16'd896},
      {16'd3360,16'd640},{16'd3160,16'd256},{16'd3000,16'd0}};
    if (i < OCV_ENTRIES) return t[i];
    return {16'd3000, 16'd0};
  endfunction

  // floor((alpha*diff + 128) / 256) on a signed difference
  function automatic logic signed [31:0] ema_step(input logic [8:0] a,
                                                  input logic signed [22:0] d);
    logic signed [33:0] p;
    p = $signed({1'b0, a}) * d + 34'sd128;
    return 32'(p >>> 8);
  endfunction
endpackage

// File: sv/battery_soc_estimator_unit.sv
// ----------------------------------------------------------------------------
// battery_soc_estimator_unit
// OCV-table battery gauge with debounced charger state and EMA filters.
// ----------------------------------------------------------------------------
// Usage: present a reading on in_valid/in_data; one result per transaction
// appears on out_valid/out_data, held until out_ready.
// Configuration writes go through cfg_we/cfg_addr/cfg_wdata; the user must
// make them only while idle, the block itself does not enforce this.
// A reading that trips shutdown skips the filter and the table lookup;
// otherwise the lookup walks the table segment by segment, then divides
// bit-serially when the reading falls inside a segment.
// One item is in flight at a time; the next is taken once the result
// register is free. The gauge state word sits in a one-entry synchronous
// memory read at the start and written back at the end of each item.
// Reset clears the control state and the state memory word (written in the
// first cycle after reset, before an item is taken) and restores the
// register defaults. A stalled receiver holds the result and blocks input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_soc_estimator_unit_defines.svh"
module battery_soc_estimator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bse_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);
  // configuration
  logic [11:0] div_r;  logic signed [9:0] cal_r;  logic [9:0] chg_r;
  logic [12:0] shd_r;  logic [15:0] deb_r;
  logic [8:0]  va_r, sa_r, da_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= 12'd512; cal_r <= '0; chg_r <= 10'd100; shd_r <= 13'd3300;
      deb_r <= 16'd1000; va_r <= 9'd26; sa_r <= 9'd26; da_r <= 9'd51;
    end else if (cfg_we) begin
      case (cfg_addr)
        bse_pkg::REG_DIV: div_r <= cfg_wdata[11:0];
        bse_pkg::REG_CAL: cal_r <= $signed(cfg_wdata[9:0]);
        bse_pkg::REG_CHG: chg_r <= cfg_wdata[9:0];
        bse_pkg::REG_SHD: shd_r <= cfg_wdata[12:0];
        bse_pkg::REG_DEB: deb_r <= cfg_wdata;
        bse_pkg::REG_VA:  va_r <= cfg_wdata[8:0];
        bse_pkg::REG_SA:  sa_r <= cfg_wdata[8:0];
        bse_pkg::REG_DA:  da_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  bse_pkg::state_t   st_r, st_nxt;
  bse_pkg::in_item_t it_r;
  bse_pkg::gauge_t   g_r, g_nxt, mem_rd, mem_wd;
  logic              mem_we, init_r;
  logic [21:0]       raw_r, raw_nxt, cur_r, cur_nxt;
  logic [15:0]       vp_r, vp_nxt;
  bse_pkg::out_item_t res_r, res_nxt;
  logic              ov_r, ov_nxt;
  bse_pkg::ocv_req_t req;
  bse_pkg::ocv_rsp_t rsp;

  bse_state_mem u_mem (.clk(clk), .we(mem_we), .wdata(mem_wd), .rdata(mem_rd));
  bse_ocv_lookup u_ocv (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bse_pkg::ST_IDLE; ov_r <= 1'b0; init_r <= 1'b1;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; init_r <= 1'b0;
    end
    if (in_valid && in_ready) it_r <= in_data;
    g_r <= g_nxt; raw_r <= raw_nxt; cur_r <= cur_nxt;
    vp_r <= vp_nxt; res_r <= res_nxt;
  end

  assign in_ready = (st_r == bse_pkg::ST_IDLE) && !ov_r && !init_r;

  always_comb begin
    logic signed [25:0] sc;
    logic [1:0] pst;
    logic signed [22:0] d;
    logic signed [23:0] t;
    logic signed [17:0] s;
    st_nxt = st_r; g_nxt = g_r; raw_nxt = raw_r; cur_nxt = cur_r;
    vp_nxt = vp_r; res_nxt = res_r; ov_nxt = ov_r;
    mem_we = 1'b0; mem_wd = g_r; req = '0;
    sc = '0; pst = '0; d = '0; t = '0; s = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (init_r) begin
      mem_we = 1'b1; mem_wd = '0;
    end
    case (st_r)
      bse_pkg::ST_IDLE: if (in_valid && in_ready) st_nxt = bse_pkg::ST_RD;
      bse_pkg::ST_RD: begin
        // memory read returns this cycle; scale the reading
        g_nxt = mem_rd;
        sc = $signed({2'b0, 24'(it_r.adc_mv * div_r)}) + 26'(cal_r * 256);
        raw_nxt = sc < 0 ? 22'd0 : (sc > 26'sd4194303 ? 22'h3FFFFF : sc[21:0]);
        st_nxt = bse_pkg::ST_PRE;
      end
      bse_pkg::ST_PRE: begin
        pst = it_r.done_active ? bse_pkg::CHG_DONE :
              (it_r.detect_active ? bse_pkg::CHG_ON : bse_pkg::CHG_DISC);
        if (!it_r.kind) begin
          g_nxt.chg = (it_r.detect_active && it_r.done_active) ? bse_pkg::CHG_DISC : pst;
          g_nxt.shd = 1'b0;
        end else if (!(it_r.detect_active && it_r.done_active)) begin
          if (pst != g_r.cand) begin
            g_nxt.cand = pst; g_nxt.since = it_r.now_ms;
          end else if ((it_r.now_ms - g_r.since) >= {16'd0, deb_r}) begin
            g_nxt.chg = g_r.cand;
          end
        end
        st_nxt = bse_pkg::ST_FILT;
      end
      bse_pkg::ST_FILT: begin
        // shutdown check, charge offset and voltage filter
        cur_nxt = raw_r;
        if (g_r.chg == bse_pkg::CHG_ON)
          cur_nxt = (raw_r < {chg_r, 8'd0}) ? 22'd0 : 22'(raw_r - {chg_r, 8'd0});
        if (it_r.kind && g_r.chg == bse_pkg::CHG_DISC && raw_r <= {1'b0, shd_r, 8'd0}) begin
          g_nxt.shd = 1'b1; st_nxt = bse_pkg::ST_WB;
        end else begin
          if (g_r.chg != bse_pkg::CHG_DISC) g_nxt.shd = 1'b0;
          if (!it_r.kind || !g_r.seeded) begin
            g_nxt.filt = cur_nxt;
          end else begin
            d = $signed({1'b0, cur_nxt}) - $signed({1'b0, g_r.filt});
            t = $signed({2'b0, g_r.filt}) + 24'(bse_pkg::ema_step(va_r, d));
            g_nxt.filt = t < 0 ? 22'd0 : (t > 24'sd4194303 ? 22'h3FFFFF : t[21:0]);
          end
          req.start = 1'b1; req.v = g_nxt.filt;
          st_nxt = bse_pkg::ST_SEARCH;
        end
      end
      bse_pkg::ST_SEARCH: if (rsp.done) begin
        vp_nxt = rsp.pct; st_nxt = bse_pkg::ST_SOC;
      end
      bse_pkg::ST_SOC: begin
        d = $signed({7'd0, vp_r}) - $signed({7'd0, g_r.soc});
        s = $signed({2'b0, g_r.soc});
        if (!it_r.kind) begin
          s = g_r.chg == bse_pkg::CHG_DONE ? 18'sd25600 : $signed({2'b0, vp_r});
        end else if (g_r.chg == bse_pkg::CHG_DONE) begin
          s = 18'sd25600;
        end else if (g_r.chg == bse_pkg::CHG_DISC) begin
          if (d < 0) s = s + 18'(bse_pkg::ema_step(sa_r, d));
        end else if (g_r.chg == bse_pkg::CHG_ON) begin
          if (d > 0) begin
            s = s + 18'(bse_pkg::ema_step(sa_r, d));
            if (s > 18'sd25344) s = 18'sd25344;
          end
        end
        g_nxt.soc = s < 0 ? 16'd0 : (s > 18'sd25600 ? 16'd25600 : s[15:0]);
        st_nxt = bse_pkg::ST_DISP;
      end
      bse_pkg::ST_DISP: begin
        d = $signed({7'd0, g_r.soc}) - $signed({7'd0, g_r.disp});
        if (!it_r.kind || !g_r.seeded || (d > -23'sd128 && d < 23'sd128)) begin
          g_nxt.disp = g_r.soc;
        end else begin
          s = $signed({2'b0, g_r.disp}) + 18'(bse_pkg::ema_step(da_r, d));
          g_nxt.disp = s < 0 ? 16'd0 : (s > 18'sd25600 ? 16'd25600 : s[15:0]);
        end
        g_nxt.seeded = 1'b1;
        st_nxt = bse_pkg::ST_WB;
      end
      bse_pkg::ST_WB: begin
        // write back and form the result
        mem_we = 1'b1; mem_wd = g_r;
        res_nxt.display_percent = g_r.disp >= 16'd25600 ? 7'd100 :
                                  7'((g_r.disp + 16'd128) >> 8);
        res_nxt.soc_q8 = g_r.soc[14:0];
        res_nxt.filtered_mv_out = g_r.filt[21:8];
        res_nxt.charger_state = g_r.chg;
        res_nxt.shutdown_needed = g_r.shd;
        st_nxt = bse_pkg::ST_OUT;
      end
      bse_pkg::ST_OUT: begin
        ov_nxt = 1'b1; st_nxt = bse_pkg::ST_IDLE;
      end
      default: st_nxt = bse_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_data = res_r;

  // no new transaction while a result waits
  `BSE_ASSERT_IMPL(a_busy, clk, rst_n, out_valid |-> !in_ready, "input taken with result pending")
  // the result register holds while stalled
  `BSE_ASSERT_IMPL(a_hold, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_data),
                   "result changed while stalled")
  // a lookup only starts from the filter step
  `BSE_ASSERT_IMPL(a_req, clk, rst_n, req.start |-> (st_r == bse_pkg::ST_FILT),
                   "lookup started out of step")
endmodule

// File: sv/bse_state_mem.sv
// ----------------------------------------------------------------------------
// bse_state_mem
// One-entry synchronous state memory with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bse_state_mem (
  input  logic           clk,
  input  logic           we,
  input  bse_pkg::gauge_t wdata,
  output bse_pkg::gauge_t rdata
);
  bse_pkg::gauge_t mem_r [0:0];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[0] <= wdata;
    end
    rdata <= mem_r[0];
  end
endmodule

// File: sv/bse_ocv_lookup.sv
// ----------------------------------------------------------------------------
// bse_ocv_lookup
// Walks the OCV table one entry a cycle, then divides bit-serially when the reading falls inside a segment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bse_ocv_lookup (
  input  logic              clk,
  input  logic              rst_n,
  input  bse_pkg::ocv_req_t req,
  output bse_pkg::ocv_rsp_t rsp
);
  localparam int IW = $clog2(bse_pkg::OCV_ENTRIES);
  typedef enum logic [1:0] {L_IDLE, L_WALK, L_DIV} lstate_t;

  lstate_t     st_r, st_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [21:0] v_r;
  logic [38:0] num_r, num_nxt;   // quotient builds in low bits
  logic [21:0] rem_r, rem_nxt;
  logic [21:0] den_r, den_nxt;
  logic [15:0] base_r, base_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [15:0] pct_r, pct_nxt;
  logic [31:0] eh, el;
  logic [21:0] vh, vl;
  logic [22:0] trial;

  always_comb begin
    eh = bse_pkg::ocv_entry(int'(idx_r));
    el = bse_pkg::ocv_entry(int'(idx_r) + 1);
    vh = {eh[29:16], 8'd0};
    vl = {el[29:16], 8'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
    idx_r <= idx_nxt; num_r <= num_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
    base_r <= base_nxt; cnt_r <= cnt_nxt; pct_r <= pct_nxt;
    if (req.start) v_r <= req.v;
  end

  // walk segments, then restoring division
  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; num_nxt = num_r; rem_nxt = rem_r;
    den_nxt = den_r; base_nxt = base_r; cnt_nxt = cnt_r; pct_nxt = pct_r;
    done_nxt = 1'b0;
    trial = '0;
    case (st_r)
      L_IDLE: begin
        if (req.start) begin
          st_nxt = L_WALK;
          idx_nxt = '0;
        end
      end
      L_WALK: begin
        if (idx_r == IW'(0) && v_r >= vh) begin
          pct_nxt = eh[15:0]; done_nxt = 1'b1; st_nxt = L_IDLE;
        end else if (v_r >= vl || int'(idx_r) + 2 >= bse_pkg::OCV_ENTRIES) begin
          if (v_r <= vl && int'(idx_r) + 2 >= bse_pkg::OCV_ENTRIES) begin
            pct_nxt = el[15:0]; done_nxt = 1'b1; st_nxt = L_IDLE;
          end else if (vh <= vl) begin
            pct_nxt = eh[15:0]; done_nxt = 1'b1; st_nxt = L_IDLE;
          end else begin
            num_nxt = 39'((v_r - vl) * (eh[15:0] - el[15:0]));
            den_nxt = vh - vl;
            base_nxt = el[15:0];
            rem_nxt = '0;
            cnt_nxt = 6'd39;
            st_nxt = L_DIV;
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      L_DIV: begin
        trial = {rem_r, num_r[38]};
        num_nxt = {num_r[37:0], 1'b0};
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = 22'(trial - {1'b0, den_r});
          num_nxt[0] = 1'b1;
        end else begin
          rem_nxt = trial[21:0];
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          pct_nxt = 16'(base_r + num_nxt[15:0]);
          done_nxt = 1'b1;
          st_nxt = L_IDLE;
        end
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.pct = pct_r;
endmodule

// File: tb/battery_soc_estimator_unit_tb.sv
// ----------------------------------------------------------------------------
// battery_soc_estimator_unit_tb
// Self-checking bench for the battery gauge: a scoreboard predicts every
// result from the accepted readings and the register settings, while random
// readings, charger pin sequences and handshake stalls drive the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module battery_soc_estimator_unit_tb;

  // Gauge prediction and result store
  class gauge_scoreboard;
    int unsigned div_q8, chg_off, shd_mv, deb_ms, va, sa, da;
    int cal;
    logic [1:0] chg, cand;
    logic [31:0] since;
    longint filt, soc, disp;
    bit shd, seeded;
    bse_pkg::out_item_t expected_q[$];
    int errors, checked;
    int unsigned ocv_mv[51] = '{
      4200, 4150, 4130, 4100, 4060, 4030, 4010, 3990, 3970, 3950, 3930, 3910, 3900,
      3890, 3880, 3870, 3860, 3850, 3840, 3830, 3820, 3810, 3800, 3790, 3780, 3770,
      3760, 3750, 3740, 3730, 3720, 3710, 3700, 3690, 3680, 3670, 3660, 3650, 3640,
      3620, 3600, 3580, 3560, 3540, 3520, 3490, 3450, 3420, 3360, 3160, 3000};
    int unsigned ocv_pct[51] = '{
      25600, 25344, 25088, 24832, 24576, 24320, 24064, 23808, 23552, 23296, 23040,
      22528, 22016, 21504, 20992, 20480, 19968, 19456, 18688, 17920, 17152, 16384,
      15616, 14848, 14080, 13312, 12544, 11776, 11008, 10240, 9472, 8704, 7936, 7168,
      6400, 5888, 5376, 4864, 4352, 3840, 3328, 2816, 2304, 2048, 1792, 1536, 1152,
      896, 640, 256, 0};

    function new();
      div_q8 = 512; cal = 0; chg_off = 100; shd_mv = 3300; deb_ms = 1000;
      va = 26; sa = 26; da = 51;
      chg = bse_pkg::CHG_DISC; cand = bse_pkg::CHG_DISC; since = 0;
      filt = 0; soc = 0; disp = 0; shd = 0; seeded = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        bse_pkg::REG_DIV: div_q8 = v[11:0];
        bse_pkg::REG_CAL: cal = $signed(v[9:0]);
        bse_pkg::REG_CHG: chg_off = v[9:0];
        bse_pkg::REG_SHD: shd_mv = v[12:0];
        bse_pkg::REG_DEB: deb_ms = v;
        bse_pkg::REG_VA:  va = v[8:0];
        bse_pkg::REG_SA:  sa = v[8:0];
        bse_pkg::REG_DA:  da = v[8:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // rounded-half-up EMA increment; arithmetic shift floors
    function longint ema_inc(int unsigned a, longint d);
      longint p;
      p = longint'(a) * d + 128;
      return p >>> 8;
    endfunction

    // interpolate the OCV table, rounding down
    function longint mv_to_pct(longint v);
      longint vh, vl, ph, pl;
      if (v >= longint'(ocv_mv[0]) * 256) return ocv_pct[0];
      if (v <= longint'(ocv_mv[50]) * 256) return ocv_pct[50];
      for (int i = 0; i < 50; i++) begin
        vh = longint'(ocv_mv[i]) * 256;
        vl = longint'(ocv_mv[i+1]) * 256;
        if (v >= vl) begin
          ph = ocv_pct[i];
          pl = ocv_pct[i+1];
          if (vh <= vl) return ph;
          return pl + ((v - vl) * (ph - pl)) / (vh - vl);
        end
      end
      return 0;
    endfunction

    function logic [1:0] pin_state(logic det, logic dn);
      return dn ? bse_pkg::CHG_DONE : (det ? bse_pkg::CHG_ON : bse_pkg::CHG_DISC);
    endfunction

    function void note_input(bse_pkg::in_item_t it);
      longint raw, cur, vp, d, s;
      logic [1:0] nxt;
      bse_pkg::out_item_t o;
      raw = clip(longint'(it.adc_mv) * div_q8 + longint'(cal) * 256, 0,
                 bse_pkg::MV_Q8_MAX);
      if (it.kind == 1'b0) begin
        chg = (it.detect_active && it.done_active) ? bse_pkg::CHG_DISC
            : pin_state(it.detect_active, it.done_active);
        cur = raw;
        if (chg == bse_pkg::CHG_ON)
          cur = clip(cur - longint'(chg_off) * 256, 0, bse_pkg::MV_Q8_MAX);
        filt = cur;
        soc = (chg == bse_pkg::CHG_DONE) ? bse_pkg::PCT_FULL : mv_to_pct(cur);
        disp = soc;
        shd = 0;
        seeded = 1;
      end else begin
        // contradictory pins hold both states
        if (!(it.detect_active && it.done_active)) begin
          nxt = pin_state(it.detect_active, it.done_active);
          if (nxt != cand) begin
            cand = nxt;
            since = it.now_ms;
          end else if (32'(it.now_ms - since) >= deb_ms) begin
            chg = cand;
          end
        end
        if (chg == bse_pkg::CHG_DISC && raw <= longint'(shd_mv) * 256) begin
          shd = 1;
        end else begin
          if (chg != bse_pkg::CHG_DISC) shd = 0;
          cur = raw;
          if (chg == bse_pkg::CHG_ON)
            cur = clip(cur - longint'(chg_off) * 256, 0, bse_pkg::MV_Q8_MAX);
          filt = seeded ? clip(filt + ema_inc(va, cur - filt), 0, bse_pkg::MV_Q8_MAX)
                        : cur;
          vp = mv_to_pct(filt);
          s = soc;
          d = vp - s;
          if (chg == bse_pkg::CHG_DONE) s = bse_pkg::PCT_FULL;
          else if (chg == bse_pkg::CHG_DISC) begin
            if (d < 0) s += ema_inc(sa, d);
          end else if (chg == bse_pkg::CHG_ON) begin
            if (d > 0) begin
              s += ema_inc(sa, d);
              if (s > bse_pkg::PCT_CAP) s = bse_pkg::PCT_CAP;
            end
          end
          soc = clip(s, 0, bse_pkg::PCT_FULL);
          if (!seeded) disp = soc;
          else begin
            d = soc - disp;
            if (d > -128 && d < 128) disp = soc;
            else disp = clip(disp + ema_inc(da, d), 0, bse_pkg::PCT_FULL);
          end
          seeded = 1;
        end
      end
      if (disp <= 0) o.display_percent = 0;
      else if (disp >= bse_pkg::PCT_FULL) o.display_percent = 100;
      else o.display_percent = 7'((disp + 128) >> 8);
      o.soc_q8 = 15'(soc);
      o.filtered_mv_out = 14'(filt >> 8);
      o.charger_state = chg;
      o.shutdown_needed = shd;
      expected_q.push_back(o);
    endfunction

    function void cmp(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s expected %0d actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(bse_pkg::out_item_t got);
      bse_pkg::out_item_t e;
      checked++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("display_percent", e.display_percent, got.display_percent);
      cmp("soc_q8", e.soc_q8, got.soc_q8);
      cmp("filtered_mv_out", e.filtered_mv_out, got.filtered_mv_out);
      cmp("charger_state", e.charger_state, got.charger_state);
      cmp("shutdown_needed", e.shutdown_needed, got.shutdown_needed);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bse_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bse_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  gauge_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent = 0;
  int cfg_writes = 0;
  logic [31:0] clock_ms;
  int cur_cal = 0;
  int unsigned cur_div = 512;

  battery_soc_estimator_unit dut (.*);

  always #2 clk = ~clk;

  // Take results and stall the receiver at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #5ms;
    $display("battery_soc_estimator_unit: mismatch");
    $finish;
  end

  // Present one reading and hold it until accepted
  task automatic send(bse_pkg::in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    sent++;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain, let the block settle, then write all eight registers
  task automatic load_regs(int unsigned v[8]);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_wdata <= 16'(v[i]);
      @(posedge clk);
      sb.set_reg(3'(i), 16'(v[i]));
      cfg_writes++;
    end
    cfg_we <= 1'b0;
    cur_div = v[0][11:0];
    cur_cal = $signed(v[1][9:0]);
  endtask

  function automatic bse_pkg::in_item_t mk(bit kind, int adc, bit det, bit dn,
                                           logic [31:0] t);
    bse_pkg::in_item_t it;
    it.kind = kind;
    it.adc_mv = 12'(adc);
    it.detect_active = det;
    it.done_active = dn;
    it.now_ms = t;
    return it;
  endfunction

  // ADC code that lands near a battery voltage under the current settings
  function automatic int adc_for(int mv);
    int a;
    a = ((mv - cur_cal) * 256) / int'(cur_div == 0 ? 1 : cur_div);
    return a < 0 ? 0 : (a > 4095 ? 4095 : a);
  endfunction

  // Seeded sessions: realistic drift, pin changes, occasional noise
  task automatic run_sessions(int n);
    int mv, cnt;
    bit det, dn;
    cnt = 0;
    while (cnt < n) begin
      mv = $urandom_range(2900, 4300);
      det = $urandom_range(1);
      dn = ($urandom_range(3) == 0);
      clock_ms = $urandom;
      send(mk(1'b0, adc_for(mv), det, dn, clock_ms));
      cnt++;
      repeat ($urandom_range(10, 40)) begin
        if (cnt >= n) break;
        if ($urandom_range(99) < 8) begin
          det = $urandom_range(1);
          dn = $urandom_range(1);
        end
        case ($urandom_range(19))
          0: clock_ms += $urandom;
          1, 2, 3: clock_ms += $urandom_range(0, 70000);
          default: clock_ms += $urandom_range(0, 1500);
        endcase
        mv += $signed($urandom_range(0, 60)) - (det ? 20 : 40);
        if (mv < 2800) mv = 2800;
        if (mv > 4400) mv = 4400;
        if ($urandom_range(9) == 0)
          send(mk($urandom_range(3) != 0, $urandom_range(4095), $urandom_range(1),
                  $urandom_range(1), $urandom));
        else
          send(mk(1'b1, adc_for(mv + $urandom_range(0, 20) - 10), det, dn, clock_ms));
        cnt++;
      end
    end
  endtask

  initial begin
    int unsigned settings[6][8];
    settings[0] = '{512, 0, 100, 3300, 1000, 26, 26, 51};
    settings[1] = '{256, 10'h20C, 0, 2500, 0, 1, 1, 1};
    settings[2] = '{4095, 500, 1000, 4200, 65535, 256, 256, 256};
    settings[3] = '{600, 10'h3CE, 333, 3400, 250, 511, 0, 300};
    settings[4] = '{700, 123, 777, 3000, 5, 128, 200, 0};
    settings[5] = '{1024, 10'h3F0, 50, 3500, 20000, 64, 100, 170};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: update before any seed, shutdown, seeds, pins, debounce, wrap
    send(mk(1'b1, 4095, 1'b0, 1'b0, 32'd0));
    send(mk(1'b1, 0, 1'b0, 1'b0, 32'd10));
    send(mk(1'b1, 1650, 1'b0, 1'b0, 32'd20));
    send(mk(1'b1, 2000, 1'b0, 1'b0, 32'd30));
    send(mk(1'b0, 1900, 1'b1, 1'b1, 32'd40));
    send(mk(1'b0, 2100, 1'b0, 1'b1, 32'd50));
    send(mk(1'b0, 1850, 1'b1, 1'b0, 32'd60));
    send(mk(1'b0, 0, 1'b0, 1'b0, 32'd70));
    send(mk(1'b0, 4095, 1'b0, 1'b0, 32'd80));
    send(mk(1'b0, 1880, 1'b0, 1'b0, 32'd90));
    send(mk(1'b1, 1870, 1'b1, 1'b0, 32'd100));
    send(mk(1'b1, 1870, 1'b1, 1'b0, 32'd1099));
    send(mk(1'b1, 1875, 1'b1, 1'b0, 32'd1100));
    send(mk(1'b1, 1880, 1'b1, 1'b1, 32'd5000));
    send(mk(1'b1, 2100, 1'b0, 1'b1, 32'hFFFF_FF00));
    send(mk(1'b1, 2100, 1'b0, 1'b1, 32'h0000_02E8));
    send(mk(1'b1, 2100, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send(mk(1'b1, 1700, 1'b0, 1'b0, 32'h0000_1000));
    send(mk(1'b1, 1600, 1'b0, 1'b0, 32'h0001_0000));
    send(mk(1'b1, 1600, 1'b0, 1'b0, 32'h7FFF_FFFF));
    send(mk(1'b1, 4095, 1'b1, 1'b0, 32'hAAAA_5555));

    // Random phases: receiver-heavy idle, sender-heavy idle, then none
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 59 : 0;
      recv_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 19 : 0;
      load_regs(settings[ph]);
      run_sessions(170);
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Covered %0d readings, %0d results, %0d register writes over six settings",
             sent, sb.checked, cfg_writes);
    $display("Phases mixed seeds, debounced pin changes, shutdown and stalls on both sides");
    if (sb.errors == 0) begin
      $display("battery_soc_estimator_unit: match");
    end else begin
      $display("battery_soc_estimator_unit: mismatch");
    end
    $finish;
  end
endmodule
